// File: src/gsef_pkg.sv
`default_nettype none
package gsef_pkg;

   // sizes
   localparam int MAX_VERTICES = 64;
   localparam int VTX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = VTX_W + 1;
   localparam int COORD_W      = 16;
   localparam int LEN_W        = 25;
   localparam int DIST_W       = 32;
   localparam int STRETCH_W    = 16;
   localparam int SQ_W         = 2 * COORD_W;
   localparam int ROOT_W       = SQ_W / 2 + 9;
   localparam int RAD_W        = 2 * ROOT_W;
   localparam int PROD_W       = STRETCH_W + LEN_W;
   localparam int CSR_W        = 16;

   // register indexes and reset values
   localparam logic CSR_STRETCH = 1'b0;
   localparam logic CSR_COUNT   = 1'b1;
   localparam logic [STRETCH_W-1:0] STRETCH_RESET = STRETCH_W'(512);
   localparam logic [CNT_W-1:0]     COUNT_RESET   = CNT_W'(MAX_VERTICES);
   localparam logic [DIST_W-1:0]    UNREACHABLE   = '1;

   typedef enum logic [1:0] {
      ACT_SET_POINT   = 2'd0,
      ACT_OFFER_EDGE  = 2'd1,
      ACT_CLEAR_EDGES = 2'd2
   } action_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_INIT, ST_SCAN_RD, ST_SCAN_CMP, ST_SCAN_DONE,
      ST_ROW_WAIT, ST_REL_CHK, ST_REL_PT, ST_REL_SQX, ST_REL_SQY, ST_REL_SQRT,
      ST_REL_UPD, ST_FIN_RD, ST_FIN_DEC, ST_ADD_A, ST_ADD_AW, ST_ADD_B,
      ST_ADD_BW, ST_RESP
   } state_type;

   typedef struct packed {
      action_type                 action;
      logic [VTX_W-1:0]           vertex_a;
      logic [VTX_W-1:0]           vertex_b;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic [LEN_W-1:0]           edge_length;
   } req_type;

   typedef struct packed {
      logic                edge_added;
      logic                target_reachable;
      logic [DIST_W-1:0]   path_length;
   } rsp_type;

endpackage
`default_nettype wire

// File: src/gsef_ram.sv
`default_nettype none
module gsef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/gsef_sqrt.sv
`default_nettype none
module gsef_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [gsef_pkg::RAD_W-1:0] value,
   output logic                            busy,
   output logic [gsef_pkg::ROOT_W-1:0]     root
);

   localparam int IT_W = $clog2(gsef_pkg::ROOT_W + 1);

   logic                          busy_ff, busy_in;
   logic [IT_W-1:0]               iter_ff, iter_in;
   logic [gsef_pkg::RAD_W-1:0]    rad_ff, rad_in;
   logic [gsef_pkg::ROOT_W:0]     rem_ff, rem_in;
   logic [gsef_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic [gsef_pkg::ROOT_W+2:0]   rem_sh;
   logic [gsef_pkg::ROOT_W+2:0]   trial;
   logic [gsef_pkg::ROOT_W+2:0]   diff;

   // one result bit per cycle, restoring square root
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[gsef_pkg::RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = rem_sh - trial;
      busy_in = busy_ff;
      iter_in = iter_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = IT_W'(gsef_pkg::ROOT_W);
         rad_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[gsef_pkg::RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = diff[gsef_pkg::ROOT_W:0];
            root_in = {root_ff[gsef_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[gsef_pkg::ROOT_W:0];
            root_in = {root_ff[gsef_pkg::ROOT_W-2:0], 1'b0};
         end
         iter_in = iter_ff - IT_W'(1);
         if (iter_ff == IT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// File: src/greedy_spanner_edge_filter.sv
`default_nettype none
// set_point, clear_edges and no-op items pass from idle through dispatch to the response state
// offer_edge in range: an init pass over the vertices, then per settled vertex a distance scan,
// a row walk and, per spanner neighbor, a square root in the square root unit
// throughput: one item at a time; the input stalls until the result is registered
// reset: control state and the valid bits of the point and row stores are cleared and
// the configuration registers take their reset values at once; no clearing pass
module greedy_spanner_edge_filter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire gsef_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output gsef_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [gsef_pkg::CSR_W-1:0] csr_wdata
);

   localparam int NV = gsef_pkg::MAX_VERTICES;
   localparam int VW = gsef_pkg::VTX_W;
   localparam int CW = gsef_pkg::CNT_W;
   localparam int XW = gsef_pkg::COORD_W;
   localparam int DW = gsef_pkg::DIST_W;

   gsef_pkg::state_type state_ff, state_in;
   gsef_pkg::req_type   req_ff, req_in;
   gsef_pkg::rsp_type   res_ff, res_in;
   gsef_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [gsef_pkg::STRETCH_W-1:0] stretch_ff, stretch_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [NV-1:0]       pvalid_ff, pvalid_in;
   logic [NV-1:0]       avalid_ff, avalid_in;
   logic [NV-1:0]       settled_ff, settled_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [VW-1:0]       best_ff, best_in;
   logic                found_ff, found_in;
   logic [DW-1:0]       bd_ff, bd_in;
   logic signed [XW-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [XW-1:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic [gsef_pkg::SQ_W-1:0]   sq_ff, sq_in;
   logic [NV-1:0]       row_ff, row_in;
   logic [gsef_pkg::PROD_W-1:0] prod_ff, prod_in;

   // memory ports
   logic                pt_we;
   logic [VW-1:0]       pt_raddr;
   logic [2*XW-1:0]     pt_rdata;
   logic                adj_we;
   logic [VW-1:0]       adj_waddr, adj_raddr;
   logic [NV-1:0]       adj_wdata, adj_rdata;
   logic                dist_we;
   logic [VW-1:0]       dist_raddr;
   logic [DW-1:0]       dist_wdata, dist_rdata;

   // shared arithmetic
   logic                sqrt_start, sqrt_busy;
   logic [gsef_pkg::RAD_W-1:0]  sqrt_value;
   logic [gsef_pkg::ROOT_W-1:0] sqrt_root;
   logic [XW-1:0]       mul_op;
   logic [gsef_pkg::SQ_W-1:0]   mul_res;
   logic [gsef_pkg::SQ_W:0]     sq_sum;
   logic [DW:0]         alt_sum;
   logic [DW-1:0]       alt;
   logic signed [XW-1:0] nx, ny;
   logic signed [XW:0]  ddx, ddy;
   logic [CW-1:0]       last;
   logic [CW-1:0]       csr_cnt;
   logic [DW-1:0]       d_val;
   logic                reach, add;
   logic [NV-1:0]       row_cur;

   gsef_ram #(.WIDTH(2 * XW), .DEPTH(NV)) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (req_ff.vertex_a),
      .wr_data ({req_ff.coord_x, req_ff.coord_y}),
      .rd_addr (pt_raddr),
      .rd_data (pt_rdata)
   );

   gsef_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   gsef_ram #(.WIDTH(DW), .DEPTH(NV)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (cnt_ff[VW-1:0]),
      .wr_data (dist_wdata),
      .rd_addr (dist_raddr),
      .rd_data (dist_rdata)
   );

   gsef_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sqrt_start),
      .value  (sqrt_value),
      .busy   (sqrt_busy),
      .root   (sqrt_root)
   );

   // datapath terms
   always_comb begin
      last    = count_ff - CW'(1);
      mul_op  = (state_ff == gsef_pkg::ST_REL_SQX) ? dx_ff : dy_ff;
      mul_res = mul_op * mul_op;
      sq_sum  = {1'b0, sq_ff} + {1'b0, mul_res};
      sqrt_value = {1'b0, sq_sum, 16'd0};
      alt_sum = {1'b0, bd_ff} + (DW + 1)'(sqrt_root);
      alt     = alt_sum[DW] ? gsef_pkg::UNREACHABLE : alt_sum[DW-1:0];
      nx      = pvalid_ff[cnt_ff[VW-1:0]] ? pt_rdata[2*XW-1:XW] : '0;
      ny      = pvalid_ff[cnt_ff[VW-1:0]] ? pt_rdata[XW-1:0] : '0;
      ddx     = {bx_ff[XW-1], bx_ff} - {nx[XW-1], nx};
      ddy     = {by_ff[XW-1], by_ff} - {ny[XW-1], ny};
      d_val   = dist_rdata;
      reach   = (d_val != gsef_pkg::UNREACHABLE);
      add     = !reach || ({1'b0, d_val, 8'd0} > prod_ff);
      row_cur = avalid_ff[adj_raddr] ? adj_rdata : '0;
      if (csr_wdata[CW-1:0] == '0) begin
         csr_cnt = CW'(1);
      end else if (csr_wdata[CW-1:0] > CW'(NV)) begin
         csr_cnt = CW'(NV);
      end else begin
         csr_cnt = csr_wdata[CW-1:0];
      end
   end

   // sequencer: next state, memory controls and register updates
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      res_in     = res_ff;
      rsp_in     = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      stretch_in = stretch_ff;
      count_in   = count_ff;
      pvalid_in  = pvalid_ff;
      avalid_in  = avalid_ff;
      settled_in = settled_ff;
      cnt_in     = cnt_ff;
      best_in    = best_ff;
      found_in   = found_ff;
      bd_in      = bd_ff;
      bx_in      = bx_ff;
      by_in      = by_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      sq_in      = sq_ff;
      row_in     = row_ff;
      prod_in    = prod_ff;
      pt_we      = 1'b0;
      pt_raddr   = cnt_ff[VW-1:0];
      adj_we     = 1'b0;
      adj_waddr  = req_ff.vertex_a;
      adj_wdata  = row_cur | (NV'(1) << req_ff.vertex_b);
      adj_raddr  = best_ff;
      dist_we    = 1'b0;
      dist_wdata = alt;
      dist_raddr = cnt_ff[VW-1:0];
      sqrt_start = 1'b0;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            gsef_pkg::CSR_STRETCH: stretch_in = csr_wdata[gsef_pkg::STRETCH_W-1:0];
            gsef_pkg::CSR_COUNT:   count_in = csr_cnt;
            default: ;
         endcase
      end

      case (state_ff)
         gsef_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = gsef_pkg::ST_DISPATCH;
            end
         end
         gsef_pkg::ST_DISPATCH: begin
            res_in   = '0;
            state_in = gsef_pkg::ST_RESP;
            case (req_ff.action)
               gsef_pkg::ACT_SET_POINT: begin
                  pt_we = 1'b1;
                  pvalid_in[req_ff.vertex_a] = 1'b1;
               end
               gsef_pkg::ACT_CLEAR_EDGES: begin
                  avalid_in = '0;
               end
               gsef_pkg::ACT_OFFER_EDGE: begin
                  if (CW'(req_ff.vertex_a) >= count_ff || CW'(req_ff.vertex_b) >= count_ff)
                  begin
                     res_in.path_length = gsef_pkg::UNREACHABLE;
                  end else begin
                     cnt_in     = '0;
                     settled_in = '0;
                     state_in   = gsef_pkg::ST_INIT;
                  end
               end
               default: ;
            endcase
         end
         // distances to unreachable, source to zero
         gsef_pkg::ST_INIT: begin
            dist_we    = 1'b1;
            dist_wdata = (cnt_ff[VW-1:0] == req_ff.vertex_a) ? '0 : gsef_pkg::UNREACHABLE;
            if (cnt_ff == last) begin
               cnt_in   = '0;
               bd_in    = gsef_pkg::UNREACHABLE;
               found_in = 1'b0;
               state_in = gsef_pkg::ST_SCAN_RD;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         // minimum scan over unsettled vertices, lowest index wins ties
         gsef_pkg::ST_SCAN_RD: begin
            state_in = gsef_pkg::ST_SCAN_CMP;
         end
         gsef_pkg::ST_SCAN_CMP: begin
            if (!settled_ff[cnt_ff[VW-1:0]] && dist_rdata < bd_ff) begin
               bd_in    = dist_rdata;
               best_in  = cnt_ff[VW-1:0];
               found_in = 1'b1;
            end
            if (cnt_ff == last) begin
               state_in = gsef_pkg::ST_SCAN_DONE;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = gsef_pkg::ST_SCAN_RD;
            end
         end
         gsef_pkg::ST_SCAN_DONE: begin
            pt_raddr = best_ff;
            if (!found_ff) begin
               state_in = gsef_pkg::ST_FIN_RD;
            end else begin
               settled_in[best_ff] = 1'b1;
               if (best_ff == req_ff.vertex_b) begin
                  state_in = gsef_pkg::ST_FIN_RD;
               end else begin
                  state_in = gsef_pkg::ST_ROW_WAIT;
               end
            end
         end
         gsef_pkg::ST_ROW_WAIT: begin
            row_in   = row_cur;
            bx_in    = pvalid_ff[best_ff] ? pt_rdata[2*XW-1:XW] : '0;
            by_in    = pvalid_ff[best_ff] ? pt_rdata[XW-1:0] : '0;
            cnt_in   = '0;
            state_in = gsef_pkg::ST_REL_CHK;
         end
         // walk the neighbor row
         gsef_pkg::ST_REL_CHK: begin
            if (row_ff[cnt_ff[VW-1:0]]) begin
               state_in = gsef_pkg::ST_REL_PT;
            end else if (cnt_ff == last) begin
               cnt_in   = '0;
               bd_in    = gsef_pkg::UNREACHABLE;
               found_in = 1'b0;
               state_in = gsef_pkg::ST_SCAN_RD;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         gsef_pkg::ST_REL_PT: begin
            dx_in    = ddx[XW] ? XW'(-ddx) : ddx[XW-1:0];
            dy_in    = ddy[XW] ? XW'(-ddy) : ddy[XW-1:0];
            state_in = gsef_pkg::ST_REL_SQX;
         end
         gsef_pkg::ST_REL_SQX: begin
            sq_in    = mul_res;
            state_in = gsef_pkg::ST_REL_SQY;
         end
         gsef_pkg::ST_REL_SQY: begin
            sqrt_start = 1'b1;
            state_in   = gsef_pkg::ST_REL_SQRT;
         end
         gsef_pkg::ST_REL_SQRT: begin
            if (!sqrt_busy) begin
               state_in = gsef_pkg::ST_REL_UPD;
            end
         end
         // relax one neighbor with the saturated path sum
         gsef_pkg::ST_REL_UPD: begin
            dist_we = (alt < dist_rdata);
            if (cnt_ff == last) begin
               cnt_in   = '0;
               bd_in    = gsef_pkg::UNREACHABLE;
               found_in = 1'b0;
               state_in = gsef_pkg::ST_SCAN_RD;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = gsef_pkg::ST_REL_CHK;
            end
         end
         // read the target distance and form the stretch bound
         gsef_pkg::ST_FIN_RD: begin
            dist_raddr = req_ff.vertex_b;
            prod_in    = stretch_ff * req_ff.edge_length;
            state_in   = gsef_pkg::ST_FIN_DEC;
         end
         gsef_pkg::ST_FIN_DEC: begin
            res_in.edge_added       = add;
            res_in.target_reachable = reach;
            res_in.path_length      = d_val;
            state_in = add ? gsef_pkg::ST_ADD_A : gsef_pkg::ST_RESP;
         end
         // insert the edge into both rows
         gsef_pkg::ST_ADD_A: begin
            adj_raddr = req_ff.vertex_a;
            state_in  = gsef_pkg::ST_ADD_AW;
         end
         gsef_pkg::ST_ADD_AW: begin
            adj_raddr = req_ff.vertex_a;
            adj_we    = 1'b1;
            avalid_in[req_ff.vertex_a] = 1'b1;
            state_in  = gsef_pkg::ST_ADD_B;
         end
         gsef_pkg::ST_ADD_B: begin
            adj_raddr = req_ff.vertex_b;
            state_in  = gsef_pkg::ST_ADD_BW;
         end
         gsef_pkg::ST_ADD_BW: begin
            adj_raddr = req_ff.vertex_b;
            adj_we    = 1'b1;
            adj_waddr = req_ff.vertex_b;
            adj_wdata = row_cur | (NV'(1) << req_ff.vertex_a);
            avalid_in[req_ff.vertex_b] = 1'b1;
            state_in  = gsef_pkg::ST_RESP;
         end
         // hand the item to the output register
         gsef_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = gsef_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gsef_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsef_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         stretch_ff   <= gsef_pkg::STRETCH_RESET;
         count_ff     <= gsef_pkg::COUNT_RESET;
         pvalid_ff    <= '0;
         avalid_ff    <= '0;
         settled_ff   <= '0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         stretch_ff   <= stretch_in;
         count_ff     <= count_in;
         pvalid_ff    <= pvalid_in;
         avalid_ff    <= avalid_in;
         settled_ff   <= settled_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
      end
      req_ff  <= req_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      best_ff <= best_in;
      bd_ff   <= bd_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sq_ff   <= sq_in;
      row_ff  <= row_in;
      prod_ff <= prod_in;
   end

   assign req_stall = (state_ff != gsef_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a reachable target never reports the unreachable distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.target_reachable |-> rsp_ff.path_length != gsef_pkg::UNREACHABLE)
      else $error("reachable item with unreachable distance");

   // the root unit only runs while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      sqrt_busy |-> state_ff == gsef_pkg::ST_REL_SQRT)
      else $error("square root busy outside its wait state");

   // distance store is written only by init or relaxation
   assert property (@(posedge clock) disable iff (reset)
      dist_we |-> state_ff == gsef_pkg::ST_INIT || state_ff == gsef_pkg::ST_REL_UPD)
      else $error("distance write outside search");

   // an added edge leaves both rows marked valid
   assert property (@(posedge clock) disable iff (reset)
      state_ff == gsef_pkg::ST_ADD_BW |=>
         avalid_ff[req_ff.vertex_a] && avalid_ff[req_ff.vertex_b])
      else $error("edge insert left a row invalid");
`endif

endmodule
`default_nettype wire
